[hdl/cbds_pkg.sv]
// Shared types and constants of the canvas brush and decal stamper.
`timescale 1ns / 1ps

package cbds_pkg;

  // Operation codes carried by the func field. Codes above FN_READ mean nothing.
  typedef enum logic [2:0] {
    FN_CLEAR = 3'd0,
    FN_BRUSH = 3'd1,
    FN_DECAL = 3'd2,
    FN_LOAD  = 3'd3,
    FN_READ  = 3'd4
  } func_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CANVAS_W = 3'd0,
    CFG_CANVAS_H = 3'd1,
    CFG_BRUSH_R  = 3'd2,
    CFG_DECAL_W  = 3'd3,
    CFG_DECAL_H  = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_SCAN,
    ST_DRAIN,
    ST_RD_ADDR,
    ST_DONE
  } ctl_state_e;

  localparam logic [31:0] PIX_WHITE    = 32'hFFFF_FFFF;
  localparam logic [31:0] PIX_BLACK    = 32'hFF00_0000;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;

  // Saturated configuration as seen by the datapath.
  typedef struct packed {
    logic [8:0] w;
    logic [8:0] h;
    logic [5:0] r;
    logic [6:0] dw;
    logic [6:0] dh;
  } cfg_t;

  // Commands from the controller.
  typedef struct packed {
    logic idle;
    logic accept;
    logic setup;
    logic sweep;
    logic scan;
    logic rd_en;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [2:0] func;
    logic       sweep_last;
    logic       scan_empty;
    logic       scan_last;
    logic       pipe_busy;
  } dp_status_t;

  typedef struct packed {
    logic [31:0] read_pixel;
    logic        in_range;
    logic        done_res;
  } result_t;

endpackage

[hdl/cbds_ctrl.sv]
// Controller state machine of the canvas brush and decal stamper.
`timescale 1ns / 1ps

module cbds_ctrl import cbds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_free_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        unique case (status_i.func)
          FN_CLEAR:           state_d = ST_SWEEP;
          FN_BRUSH, FN_DECAL: state_d = ST_SCAN;
          FN_READ:            state_d = ST_RD_ADDR;
          default:            state_d = ST_DONE;
        endcase
      end
      ST_SWEEP: begin
        if (status_i.sweep_last) state_d = ST_DONE;
      end
      ST_SCAN: begin
        if (status_i.scan_empty || status_i.scan_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) state_d = ST_DONE;
      end
      ST_RD_ADDR: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.idle     = (state_q == ST_IDLE);
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.setup    = (state_q == ST_SETUP);
    cmd_o.sweep    = (state_q == ST_INIT) || (state_q == ST_SWEEP);
    cmd_o.scan     = (state_q == ST_SCAN);
    cmd_o.rd_en    = (state_q == ST_RD_ADDR);
    cmd_o.out_load = (state_q == ST_DONE) && out_free_i;
  end

endmodule

[hdl/cbds_dp.sv]
// Datapath of the canvas brush and decal stamper: scan counters, pixel pipeline and stores.
`timescale 1ns / 1ps

module cbds_dp import cbds_pkg::*; #(
  parameter int FRAME_DEPTH = 65536,
  parameter int DECAL_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  input  cfg_t        cfg_i,
  input  logic [2:0]  func_i,
  input  logic [10:0] pos_x_i,
  input  logic [10:0] pos_y_i,
  input  logic [11:0] decal_index_i,
  input  logic [31:0] pixel_value_i,
  output dp_status_t  status_o,
  output result_t     result_o
);

  localparam int FA_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int DA_W = (DECAL_DEPTH > 1) ? $clog2(DECAL_DEPTH) : 1;

  // Captured transaction.
  logic [2:0]  func_q;
  logic [10:0] x_q, y_q;
  logic [11:0] didx_q;
  logic [31:0] pval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      x_q    <= pos_x_i;
      y_q    <= pos_y_i;
      didx_q <= decal_index_i;
      pval_q <= pixel_value_i;
    end
  end

  // Sweep counter, shared by the power-up fill and the clear operation.
  logic [17:0]     area;
  logic [FA_W-1:0] clr_cnt_q, clr_end_q;
  logic            clr_empty_q;
  logic            sweep_last;

  assign area       = 18'(cfg_i.w) * 18'(cfg_i.h);
  assign sweep_last = clr_empty_q || (clr_cnt_q == clr_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      clr_end_q   <= FA_W'(FRAME_DEPTH - 1);
      clr_empty_q <= 1'b0;
    end else if (cmd_i.setup) begin
      clr_cnt_q   <= '0;
      clr_end_q   <= FA_W'(area - 18'd1);
      clr_empty_q <= (area == 18'd0);
    end else if (cmd_i.sweep) begin
      clr_cnt_q <= sweep_last ? '0 : FA_W'(clr_cnt_q + 1'b1);
    end
  end

  // Scan window set up per operation.
  logic        brush;
  logic [5:0]  half_w, half_h;
  logic [5:0]  half_w_q, half_h_q;
  logic [11:0] rr_q;
  logic        brush_q;
  logic [6:0]  dw_q;
  logic [6:0]  col_q, row_q;
  logic [13:0] rowbase_q;
  logic        scan_empty, col_last, scan_last, s0_v;

  assign brush  = (func_q == FN_BRUSH);
  assign half_w = brush ? cfg_i.r : cfg_i.dw[6:1];
  assign half_h = brush ? cfg_i.r : cfg_i.dh[6:1];

  assign scan_empty = (half_w_q == 6'd0) || (half_h_q == 6'd0);
  assign col_last   = (col_q == 7'({half_w_q, 1'b0} - 7'd1));
  assign scan_last  = col_last && (row_q == 7'({half_h_q, 1'b0} - 7'd1));
  assign s0_v       = cmd_i.scan && !scan_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_w_q  <= '0;
      half_h_q  <= '0;
      rr_q      <= '0;
      brush_q   <= 1'b0;
      dw_q      <= '0;
      col_q     <= '0;
      row_q     <= '0;
      rowbase_q <= '0;
    end else if (cmd_i.setup) begin
      half_w_q  <= half_w;
      half_h_q  <= half_h;
      rr_q      <= 12'(cfg_i.r) * 12'(cfg_i.r);
      brush_q   <= brush;
      dw_q      <= cfg_i.dw;
      col_q     <= '0;
      row_q     <= '0;
      rowbase_q <= '0;
    end else if (s0_v) begin
      if (col_last) begin
        col_q     <= '0;
        row_q     <= 7'(row_q + 7'd1);
        rowbase_q <= 14'(rowbase_q + 14'(dw_q));
      end else begin
        col_q <= 7'(col_q + 7'd1);
      end
    end
  end

  // Decal store: loaded one pixel at a time, read once per scan position.
  logic [31:0]     decal_mem [DECAL_DEPTH];
  logic [31:0]     dec_rdata_q;
  logic [DA_W-1:0] dec_raddr;
  logic            dec_we;

  assign dec_raddr = DA_W'(14'(col_q) + rowbase_q);
  assign dec_we    = cmd_i.setup && (func_q == FN_LOAD) &&
                     ({20'd0, didx_q} < 32'(DECAL_DEPTH));

  always_ff @(posedge clk_i) begin
    if (dec_we) decal_mem[DA_W'(didx_q)] <= pval_q;
    if (s0_v && !brush_q) dec_rdata_q <= decal_mem[dec_raddr];
  end

  // Stage 1: offsets and target coordinates.
  logic signed [7:0]  s0_dx, s0_dy;
  logic signed [11:0] s0_tx, s0_ty;
  logic               s1_v_q;
  logic signed [7:0]  s1_dx_q, s1_dy_q;
  logic signed [11:0] s1_tx_q, s1_ty_q;

  assign s0_dx = $signed({1'b0, col_q}) - $signed({2'b00, half_w_q});
  assign s0_dy = $signed({1'b0, row_q}) - $signed({2'b00, half_h_q});
  assign s0_tx = $signed({x_q[10], x_q}) + $signed({{4{s0_dx[7]}}, s0_dx});
  assign s0_ty = $signed({y_q[10], y_q}) + $signed({{4{s0_dy[7]}}, s0_dy});

  always_ff @(posedge clk_i) begin
    s1_dx_q <= s0_dx;
    s1_dy_q <= s0_dy;
    s1_tx_q <= s0_tx;
    s1_ty_q <= s0_ty;
  end

  // Stage 2: squared distance and canvas clipping.
  logic signed [15:0] sq_x, sq_y;
  logic               s1_inr;
  logic               s2_v_q, s2_inr_q;
  logic [12:0]        s2_sq_q;
  logic [8:0]         s2_tx_q, s2_ty_q;
  logic [31:0]        s2_pix_q;

  assign sq_x   = s1_dx_q * s1_dx_q;
  assign sq_y   = s1_dy_q * s1_dy_q;
  assign s1_inr = !s1_tx_q[11] && (s1_tx_q[10:0] < {2'b00, cfg_i.w}) &&
                  !s1_ty_q[11] && (s1_ty_q[10:0] < {2'b00, cfg_i.h});

  always_ff @(posedge clk_i) begin
    s2_sq_q  <= 13'(sq_x[12:0] + sq_y[12:0]);
    s2_inr_q <= s1_inr;
    s2_tx_q  <= s1_tx_q[8:0];
    s2_ty_q  <= s1_ty_q[8:0];
    s2_pix_q <= dec_rdata_q;
  end

  // Stage 3: hit test and row base of the target address.
  logic        s2_hit;
  logic        s3_we_q;
  logic [17:0] s3_base_q;
  logic [8:0]  s3_tx_q;
  logic [31:0] s3_pix_q;

  assign s2_hit = brush_q ? (s2_sq_q < {1'b0, rr_q}) : (s2_pix_q[31:24] == ALPHA_OPAQUE);

  always_ff @(posedge clk_i) begin
    s3_base_q <= 18'(s2_ty_q) * 18'(cfg_i.w);
    s3_tx_q   <= s2_tx_q;
    s3_pix_q  <= brush_q ? PIX_BLACK : s2_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_we_q <= 1'b0;
    end else begin
      s1_v_q  <= s0_v;
      s2_v_q  <= s1_v_q;
      s3_we_q <= s2_v_q && s2_inr_q && s2_hit;
    end
  end

  // Single-pixel read setup.
  logic        rd_inr_q;
  logic [17:0] rd_base_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      rd_inr_q  <= (func_q == FN_READ) &&
                   !x_q[10] && (x_q[9:0] < {1'b0, cfg_i.w}) &&
                   !y_q[10] && (y_q[9:0] < {1'b0, cfg_i.h});
      rd_base_q <= 18'(y_q[8:0]) * 18'(cfg_i.w);
    end
  end

  // Frame store: one write port, one registered read port.
  logic [31:0]     frame_mem [FRAME_DEPTH];
  logic [31:0]     frame_rdata_q;
  logic            fr_we;
  logic [FA_W-1:0] fr_waddr, fr_raddr;
  logic [31:0]     fr_wdata;

  always_comb begin
    fr_we    = 1'b0;
    fr_waddr = clr_cnt_q;
    fr_wdata = PIX_WHITE;
    priority if (cmd_i.sweep && !clr_empty_q) begin
      fr_we = 1'b1;
    end else if (s3_we_q) begin
      fr_we    = 1'b1;
      fr_waddr = FA_W'(s3_base_q + 18'(s3_tx_q));
      fr_wdata = s3_pix_q;
    end else begin
      fr_we = 1'b0;
    end
  end

  assign fr_raddr = FA_W'(rd_base_q + 18'(x_q[8:0]));

  always_ff @(posedge clk_i) begin
    if (fr_we) frame_mem[fr_waddr] <= fr_wdata;
    if (cmd_i.rd_en && rd_inr_q) frame_rdata_q <= frame_mem[fr_raddr];
  end

  assign status_o.func       = func_q;
  assign status_o.sweep_last = sweep_last;
  assign status_o.scan_empty = scan_empty;
  assign status_o.scan_last  = scan_last;
  assign status_o.pipe_busy  = s1_v_q || s2_v_q || s3_we_q;

  assign result_o.read_pixel = rd_inr_q ? frame_rdata_q : 32'd0;
  assign result_o.in_range   = rd_inr_q;
  assign result_o.done_res   = (func_q <= FN_READ);

endmodule

[hdl/canvas_brush_and_decal_stamper_core.sv]
// Top level of the canvas brush and decal stamper: configuration, result register, wiring.
`timescale 1ns / 1ps

// A 32-bit BGRA frame buffer engine that takes one command transaction at a time and returns
// exactly one result transaction for it. func 0 fills the active canvas (width times height)
// with opaque white, func 1 stamps an opaque black disc of the configured radius, func 2 copies
// the fully opaque pixels of the stored decal centred on the given position, func 3 loads one
// decal pixel and func 4 reads one canvas pixel back; stamps are clipped at the canvas edge.
// The pixel loop runs one position per clock through a pipeline over the frame store's
// single write port; a brush scans (2r)^2 positions and a decal blit
// (decal_width & ~1) * (decal_height & ~1) positions. After reset the frame store is
// filled with white (all FRAME_DEPTH words, 65536 with the default sizes), during which no
// command transaction is accepted; configuration writes are taken at any time but must only
// be issued while the block is idle. A new command is accepted while the previous result
// still waits in the output register.

module canvas_brush_and_decal_stamper_core import cbds_pkg::*; #(
  parameter int MAX_CANVAS_W = 256,
  parameter int MAX_CANVAS_H = 256,
  parameter int MAX_RADIUS   = 32,
  parameter int MAX_DECAL_W  = 64,
  parameter int MAX_DECAL_H  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [10:0] pos_x_i,
  input  logic [10:0] pos_y_i,
  input  logic [11:0] decal_index_i,
  input  logic [31:0] pixel_value_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_pixel_o,
  output logic        in_range_o,
  output logic        done_res_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int FRAME_DEPTH = MAX_CANVAS_W * MAX_CANVAS_H;
  localparam int DECAL_DEPTH = MAX_DECAL_W * MAX_DECAL_H;

  // Configuration registers hold the written values cut to their field widths; saturation happens on the way out.
  logic [8:0] canvas_w_q, canvas_h_q;
  logic [5:0] brush_r_q;
  logic [6:0] decal_w_q, decal_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_w_q <= 9'd256;
      canvas_h_q <= 9'd256;
      brush_r_q  <= 6'd8;
      decal_w_q  <= 7'd64;
      decal_h_q  <= 7'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_CANVAS_W: canvas_w_q <= cfg_data_i;
        CFG_CANVAS_H: canvas_h_q <= cfg_data_i;
        CFG_BRUSH_R:  brush_r_q  <= cfg_data_i[5:0];
        CFG_DECAL_W:  decal_w_q  <= cfg_data_i[6:0];
        CFG_DECAL_H:  decal_h_q  <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Values above the size limits are clamped to them.
  cfg_t cfg_sat;

  assign cfg_sat.w  = (32'(canvas_w_q) > MAX_CANVAS_W) ? 9'(MAX_CANVAS_W) : canvas_w_q;
  assign cfg_sat.h  = (32'(canvas_h_q) > MAX_CANVAS_H) ? 9'(MAX_CANVAS_H) : canvas_h_q;
  assign cfg_sat.r  = (32'(brush_r_q) > MAX_RADIUS) ? 6'(MAX_RADIUS) : brush_r_q;
  assign cfg_sat.dw = (32'(decal_w_q) > MAX_DECAL_W) ? 7'(MAX_DECAL_W) : decal_w_q;
  assign cfg_sat.dh = (32'(decal_h_q) > MAX_DECAL_H) ? 7'(MAX_DECAL_H) : decal_h_q;

  // Output register: the result waits here while the next command is already being taken.
  logic       out_valid_q;
  logic       out_free;
  result_t    out_q;
  result_t    result;
  ctl_cmd_t   cmd;
  dp_status_t status;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) out_q <= result;
  end

  assign in_stall_o   = !cmd.idle;
  assign out_valid_o  = out_valid_q;
  assign read_pixel_o = out_q.read_pixel;
  assign in_range_o   = out_q.in_range;
  assign done_res_o   = out_q.done_res;

  cbds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cbds_dp #(
    .FRAME_DEPTH (FRAME_DEPTH),
    .DECAL_DEPTH (DECAL_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg_sat),
    .func_i        (func_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .decal_index_i (decal_index_i),
    .pixel_value_i (pixel_value_i),
    .status_o      (status),
    .result_o      (result)
  );

endmodule

[tb/sv/canvas_brush_and_decal_stamper_core_tb.sv]
// Self-checking testbench for the canvas brush and decal stamper core.
`timescale 1ns / 1ps

// The testbench drives command transactions into the stamper and keeps its own copy of the
// frame store, the decal store and the five configuration registers. For every accepted
// command the scoreboard computes the single result that the command must produce. It queues
// that result and compares it field by field with each accepted result transaction.
//
// The run is split into phases. Each phase reprograms all five registers while the block is
// idle. The settings include saturated values, zero canvas sizes, a zero radius, odd decal sizes
// and the exact maxima. Before any blit, every decal entry that the blit window can touch is
// loaded. This means the block never reads a decal word that was never written. Both sides
// idle in random bursts, except in calm phases and in the final phase.

module canvas_brush_and_decal_stamper_core_tb;
  import cbds_pkg::*;

  localparam int CANVAS_MAX_W = 256;
  localparam int CANVAS_MAX_H = 256;
  localparam int RADIUS_MAX   = 32;
  localparam int DECAL_MAX_W  = 64;
  localparam int DECAL_MAX_H  = 64;
  localparam int FRAME_DEPTH  = CANVAS_MAX_W * CANVAS_MAX_H;
  localparam int DECAL_DEPTH  = DECAL_MAX_W * DECAL_MAX_H;

  // Register limits and field masks, in register index order.
  localparam int REG_LIMIT [5] = '{CANVAS_MAX_W, CANVAS_MAX_H, RADIUS_MAX, DECAL_MAX_W,
                                   DECAL_MAX_H};
  localparam int REG_MASK [5]  = '{511, 511, 63, 127, 127};
  localparam int REG_RESET [5] = '{256, 256, 8, 64, 64};

  // Function codes above FN_READ are unused by the block.
  localparam logic [2:0] FN_SPARE_FIRST = 3'd5;

  // Hand-picked settings in register order: width, height, radius, decal width, decal height.
  // They cover saturation, zero canvas dimensions, a zero radius, odd decal sizes and exact
  // maxima. Later phases pick small random settings.
  localparam int FIXED_PHASES = 7;
  localparam int PHASE_CFG [FIXED_PHASES][5] = '{
    '{16, 12, 3, 4, 4},
    '{511, 511, 63, 127, 1},
    '{0, 20, 5, 2, 64},
    '{30, 0, 2, 5, 3},
    '{1, 1, 0, 3, 7},
    '{256, 3, 20, 64, 2},
    '{40, 256, 32, 0, 0}
  };

  // Random commands only; decal window loads and directed commands come on top of these.
  localparam int RANDOM_ITEMS = 1600;

  // Stamper model: it holds the pixel stores and registers and predicts the result of each
  // command.
  class stamp_scoreboard;
    bit [31:0] canvas_px [FRAME_DEPTH];
    bit [31:0] decal_px [DECAL_DEPTH];
    bit        decal_loaded [DECAL_DEPTH];
    int        regs [5];
    result_t   pending_results [$];
    int        errors;
    int        reads_hit;

    function new();
      foreach (canvas_px[i]) canvas_px[i] = PIX_WHITE;
      foreach (decal_loaded[i]) decal_loaded[i] = 1'b0;
      foreach (regs[i]) regs[i] = REG_RESET[i];
      errors = 0;
      reads_hit = 0;
    endfunction

    // Value of a register as the datapath sees it, saturated to its maximum.
    function int eff(cfg_reg_e idx);
      int v;
      v = regs[int'(idx)];
      return (v > REG_LIMIT[int'(idx)]) ? REG_LIMIT[int'(idx)] : v;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [8:0] data);
      regs[int'(idx)] = int'(data) & REG_MASK[int'(idx)];
    endfunction

    function void paint(int x, int y, int w, int h, bit [31:0] pix);
      if (x >= 0 && x < w && y >= 0 && y < h) canvas_px[x + y * w] = pix;
    endfunction

    function void note_command(logic [2:0] fn, logic [10:0] px, logic [10:0] py,
                               logic [11:0] idx, logic [31:0] pix);
      int x, y, w, h, r, dw, dh, hw, hh;
      bit [31:0] src;
      result_t res;
      x = $signed(px);
      y = $signed(py);
      w = eff(CFG_CANVAS_W);
      h = eff(CFG_CANVAS_H);
      r = eff(CFG_BRUSH_R);
      dw = eff(CFG_DECAL_W);
      dh = eff(CFG_DECAL_H);
      hw = dw / 2;
      hh = dh / 2;
      res = '0;
      res.done_res = 1'b1;
      case (fn)
        FN_CLEAR: begin
          // Only the first w*h words are cleared. Words past that keep old pixels.
          for (int i = 0; i < w * h; i++) canvas_px[i] = PIX_WHITE;
        end
        FN_BRUSH: begin
          for (int dx = -r; dx < r; dx++)
            for (int dy = -r; dy < r; dy++)
              if (dx * dx + dy * dy < r * r) paint(x + dx, y + dy, w, h, PIX_BLACK);
        end
        FN_DECAL: begin
          for (int dx = -hw; dx < hw; dx++)
            for (int dy = -hh; dy < hh; dy++) begin
              src = decal_px[(dx + hw) + (dy + hh) * dw];
              if (src[31:24] == ALPHA_OPAQUE) paint(x + dx, y + dy, w, h, src);
            end
        end
        FN_LOAD: begin
          if (int'(idx) < DECAL_DEPTH) begin
            decal_px[idx] = pix;
            decal_loaded[idx] = 1'b1;
          end
        end
        FN_READ: begin
          if (x >= 0 && x < w && y >= 0 && y < h) begin
            res.read_pixel = canvas_px[x + y * w];
            res.in_range = 1'b1;
            reads_hit++;
          end
        end
        default: res.done_res = 1'b0;
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [31:0] rd, logic inr, logic done);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with no command outstanding (read_pixel %h)",
                 $time, rd);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rd !== want.read_pixel) begin
          $display("%0t: read_pixel expected %h, got %h", $time, want.read_pixel, rd);
          errors++;
        end
        if (inr !== want.in_range) begin
          $display("%0t: in_range expected %b, got %b", $time, want.in_range, inr);
          errors++;
        end
        if (done !== want.done_res) begin
          $display("%0t: done_res expected %b, got %b", $time, want.done_res, done);
          errors++;
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  func_i;
  logic [10:0] pos_x_i;
  logic [10:0] pos_y_i;
  logic [11:0] decal_index_i;
  logic [31:0] pixel_value_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] read_pixel_o;
  logic        in_range_o;
  logic        done_res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;

  stamp_scoreboard sb = new();

  // Idling switches. tx_calm stops gaps before commands. rx_calm stops result stalls.
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int rx_hold = 0;
  int cmd_count = 0;
  int phase_count = 0;
  int phase_regs [5];

  canvas_brush_and_decal_stamper_core #(
    .MAX_CANVAS_W(CANVAS_MAX_W),
    .MAX_CANVAS_H(CANVAS_MAX_H),
    .MAX_RADIUS  (RADIUS_MAX),
    .MAX_DECAL_W (DECAL_MAX_W),
    .MAX_DECAL_H (DECAL_MAX_H)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .decal_index_i(decal_index_i),
    .pixel_value_i(pixel_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_pixel_o (read_pixel_o),
    .in_range_o   (in_range_o),
    .done_res_o   (done_res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Result stalls come in random bursts. The stall value read at an edge
  // is always the one from before that edge.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_stall_i <= 1'b1;
    end else if (!rx_calm && $urandom_range(0, 6) == 0) begin
      rx_hold = $urandom_range(0, 4);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // A result transaction completes when valid is high and the stall is low at an edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0)
      sb.check_result(read_pixel_o, in_range_o, done_res_o);
  end

  // Drives one command transaction and waits until it is accepted. Valid stays high
  // afterward. Only a gap before the next command or the drain at the end of a phase lowers it.
  task automatic send_cmd(input logic [2:0] fn, input int x, input int y,
                          input logic [11:0] idx, input logic [31:0] pix);
    int gap;
    if (!tx_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    pos_x_i <= 11'(x);
    pos_y_i <= 11'(y);
    decal_index_i <= idx;
    pixel_value_i <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_command(fn, 11'(x), 11'(y), idx, pix);
    cmd_count++;
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [8:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Stops sending and waits until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // A decal word is mostly fully opaque, so that blits copy it. Some words carry a random
  // alpha and are keyed out.
  function automatic logic [31:0] decal_word();
    if ($urandom_range(0, 4) < 3) return {ALPHA_OPAQUE, 24'($urandom)};
    return 32'($urandom);
  endfunction

  // Picks a coordinate around a span of the given extent. Now and then it picks one anywhere
  // in the 11-bit signed range.
  function automatic int pick_coord(int extent, int margin);
    if ($urandom_range(0, 9) == 0) return int'($signed(11'($urandom)));
    return -margin + int'($urandom_range(0, extent + 2 * margin - 1));
  endfunction

  // Loads every decal entry that a blit with the current decal size can read, unless the
  // entry already holds a value.
  task automatic fill_decal_window();
    int n;
    n = sb.eff(CFG_DECAL_W) * sb.eff(CFG_DECAL_H);
    for (int i = 0; i < n; i++)
      if (!sb.decal_loaded[i]) send_cmd(FN_LOAD, pick_coord(8, 2), pick_coord(8, 2),
                                        12'(i), decal_word());
  endtask

  task automatic random_command(input bit clear_ok);
    int pick, w, h, r, hw, hh, win;
    logic [11:0] idx;
    logic [31:0] pix;
    w = sb.eff(CFG_CANVAS_W);
    h = sb.eff(CFG_CANVAS_H);
    r = sb.eff(CFG_BRUSH_R);
    hw = sb.eff(CFG_DECAL_W) / 2;
    hh = sb.eff(CFG_DECAL_H) / 2;
    win = sb.eff(CFG_DECAL_W) * sb.eff(CFG_DECAL_H);
    idx = 12'($urandom);
    pix = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 35 || (pick >= 90 && !clear_ok)) begin
      send_cmd(FN_READ, pick_coord(w, 2), pick_coord(h, 2), idx, pix);
    end else if (pick < 55) begin
      send_cmd(FN_BRUSH, pick_coord(w, r + 2), pick_coord(h, r + 2), idx, pix);
    end else if (pick < 70) begin
      send_cmd(FN_DECAL, pick_coord(w, hw + 2), pick_coord(h, hh + 2), idx, pix);
    end else if (pick < 85) begin
      // Half of the loads land inside the blit window so later blits show new content.
      if (win > 0 && $urandom_range(0, 1) == 0) idx = 12'($urandom_range(0, win - 1));
      send_cmd(FN_LOAD, pick_coord(w, 2), pick_coord(h, 2), idx, decal_word());
    end else if (pick < 90) begin
      send_cmd(3'(FN_SPARE_FIRST + $urandom_range(0, 2)), pick_coord(w, 2),
               pick_coord(h, 2), idx, pix);
    end else begin
      send_cmd(FN_CLEAR, pick_coord(w, 2), pick_coord(h, 2), idx, pix);
    end
  endtask

  initial begin
    int sent, n, w, h, r;
    bit heavy, quiet;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FN_CLEAR;
    pos_x_i = '0;
    pos_y_i = '0;
    decal_index_i = '0;
    pixel_value_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_CANVAS_W;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands at the reset settings. The block is busy with its clearing pass first.
    // A read before any drawing must return the white canvas left by reset.
    send_cmd(FN_READ, 0, 0, 12'($urandom), $urandom);
    send_cmd(FN_READ, 255, 255, 12'($urandom), $urandom);
    send_cmd(FN_BRUSH, 0, 0, 12'($urandom), $urandom);
    send_cmd(FN_READ, 0, 0, 12'($urandom), $urandom);
    // These two reads check the disc edge: an offset of 7 is inside it and an offset of 8 is
    // not.
    send_cmd(FN_READ, 7, 0, 12'($urandom), $urandom);
    send_cmd(FN_READ, 8, 0, 12'($urandom), $urandom);
    send_cmd(FN_BRUSH, 255, 255, 12'($urandom), $urandom);
    send_cmd(FN_BRUSH, -1024, -1024, 12'($urandom), $urandom);
    send_cmd(FN_BRUSH, 1023, 1023, 12'($urandom), $urandom);
    send_cmd(FN_READ, 250, 250, 12'($urandom), $urandom);
    send_cmd(FN_READ, 256, 0, 12'($urandom), $urandom);
    send_cmd(FN_READ, 0, -1, 12'($urandom), $urandom);
    send_cmd(FN_READ, -1024, 1023, 12'($urandom), $urandom);
    send_cmd(FN_READ, 1023, -1024, 12'($urandom), $urandom);
    send_cmd(FN_LOAD, 0, 0, 12'd0, 32'hFFFF_FFFF);
    send_cmd(FN_LOAD, 0, 0, 12'hFFF, 32'h0000_0000);
    send_cmd(FN_SPARE_FIRST, 1023, 1023, 12'hFFF, 32'hFFFF_FFFF);
    send_cmd(3'(FN_SPARE_FIRST + 1), -1024, -1024, 12'd0, 32'd0);
    send_cmd(3'(FN_SPARE_FIRST + 2), 5, 5, 12'($urandom), $urandom);
    send_cmd(FN_CLEAR, 0, 0, 12'($urandom), $urandom);
    send_cmd(FN_READ, 0, 0, 12'($urandom), $urandom);
    send_cmd(FN_READ, 255, 255, 12'($urandom), $urandom);

    // Random phases. Each phase reprograms all registers while the block is idle.
    sent = 0;
    phase_count = 1;
    while (sent < RANDOM_ITEMS) begin
      if (phase_count <= FIXED_PHASES) begin
        foreach (phase_regs[i]) phase_regs[i] = PHASE_CFG[phase_count - 1][i];
      end else begin
        phase_regs[0] = $urandom_range(1, 48);
        phase_regs[1] = $urandom_range(1, 48);
        phase_regs[2] = $urandom_range(0, 10);
        phase_regs[3] = $urandom_range(0, 16);
        phase_regs[4] = $urandom_range(0, 16);
      end
      drain_results();
      for (int i = 0; i < 5; i++) write_reg(cfg_reg_e'(i), 9'(phase_regs[i]));
      cfg_valid_i <= 1'b0;

      w = sb.eff(CFG_CANVAS_W);
      h = sb.eff(CFG_CANVAS_H);
      r = sb.eff(CFG_BRUSH_R);
      // Large brushes and canvases are slow. Those phases are kept short, and random clears
      // happen only on small canvases.
      heavy = (r >= 16) || (w * h > 4096) ||
              (sb.eff(CFG_DECAL_W) * sb.eff(CFG_DECAL_H) > 1024);
      n = heavy ? 60 : 130;
      // The final phase runs with no idling on either side. Some earlier phases are calm too.
      quiet = (sent + n >= RANDOM_ITEMS);
      tx_calm = quiet || ($urandom_range(0, 3) == 0);
      rx_calm = quiet || ($urandom_range(0, 3) == 0);

      fill_decal_window();
      if (phase_count == 1) begin
        // These directed blits hit the top-left corner, the bottom-right corner and a spot
        // far outside the canvas.
        send_cmd(FN_DECAL, 0, 0, 12'($urandom), $urandom);
        send_cmd(FN_DECAL, w - 1, h - 1, 12'($urandom), $urandom);
        send_cmd(FN_DECAL, -1024, -1024, 12'($urandom), $urandom);
      end
      repeat (n) random_command(w * h <= 4096);
      sent += n;
      phase_count++;
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d command transactions over %0d register settings, %0d reads in range;",
             cmd_count, phase_count, sb.reads_hit);
    $display("settings included saturated, zero, odd and maximal sizes.");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("canvas_brush_and_decal_stamper_core test passed");
    end else begin
      $display("canvas_brush_and_decal_stamper_core test failed");
    end
    $finish;
  end

  // This limit ends a run that hangs and reports the test as failed.
  initial begin
    #50_000_000;
    $display("canvas_brush_and_decal_stamper_core test failed");
    $finish;
  end

endmodule
